### sv/slpg_pkg.sv
// Shared types and constants of the status LED pattern generator.
// No dependencies; the phase, core and top files and the testbench import this package.
`default_nettype none

package slpg_pkg;

    typedef enum logic [2:0] {
        MODE_BOOT        = 3'd0,
        MODE_CONNECTING  = 3'd1,
        MODE_LINK_OK     = 3'd2,
        MODE_IDLE        = 3'd3,
        MODE_CALL        = 3'd4,
        MODE_STEADY_BLUE = 3'd5,
        MODE_ALERT       = 3'd6,
        MODE_ERROR       = 3'd7
    } slpg_mode_t;

    localparam logic CMD_UPDATE   = 1'b0;
    localparam logic CMD_SET_MODE = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] now_ms;
        logic [2:0]  mode;
    } slpg_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } slpg_color_t;

    // Bit 0 of the millisecond time divided by each blink period.
    typedef struct packed {
        logic boot;
        logic call;
        logic alert;
    } slpg_phase_t;

    localparam logic [31:0] BOOT_PERIOD_MS  = 32'd200;
    localparam logic [31:0] CALL_PERIOD_MS  = 32'd300;
    localparam logic [31:0] ALERT_PERIOD_MS = 32'd500;
    localparam logic [31:0] CONN_STEP_MS    = 32'd10;
    localparam logic [31:0] IDLE_STEP_MS    = 32'd15;

    localparam logic [7:0] CONN_TOP    = 8'd100;
    localparam logic [7:0] CONN_BOTTOM = 8'd0;
    localparam logic [7:0] IDLE_TOP    = 8'd50;
    localparam logic [7:0] IDLE_BOTTOM = 8'd5;

    // Reciprocals for an exact 32-bit quotient: q = (x * RECIP) >> SHIFT,
    // with SHIFT = 32 + ceil(log2(period)).
    localparam int BOOT_SHIFT  = 40;
    localparam int CALL_SHIFT  = 41;
    localparam int ALERT_SHIFT = 41;
    localparam logic [32:0] BOOT_RECIP  = 33'((64'd1 << BOOT_SHIFT) / 64'd200 + 64'd1);
    localparam logic [32:0] CALL_RECIP  = 33'((64'd1 << CALL_SHIFT) / 64'd300 + 64'd1);
    localparam logic [32:0] ALERT_RECIP = 33'((64'd1 << ALERT_SHIFT) / 64'd500 + 64'd1);

    localparam slpg_color_t COLOR_BLACK = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
    localparam slpg_color_t COLOR_WHITE = '{red: 8'd100, green: 8'd100, blue: 8'd100};
    localparam slpg_color_t COLOR_RED   = '{red: 8'd100, green: 8'd0,   blue: 8'd0};
    localparam slpg_color_t COLOR_GREEN = '{red: 8'd0,   green: 8'd20,  blue: 8'd0};
    localparam slpg_color_t COLOR_BLUE  = '{red: 8'd0,   green: 8'd0,   blue: 8'd100};

endpackage

`default_nettype wire

### sv/slpg_if.sv
// Valid/ready channel interfaces for input items and result colors.
// Depends on nothing.
`default_nettype none

interface slpg_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] now_ms;
    logic [2:0]  mode;

    modport source (output valid, output cmd, output now_ms, output mode, input ready);
    modport sink   (input valid, input cmd, input now_ms, input mode, output ready);
endinterface

interface slpg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

### sv/slpg_phase.sv
// Blink phase of an incoming time stamp for the three blink periods.
// Depends on slpg_pkg.
`default_nettype none

module slpg_phase
    import slpg_pkg::*;
(
    input  logic [31:0] now_ms,
    output slpg_phase_t phase
);

    logic [64:0] boot_prod;
    logic [64:0] call_prod;
    logic [64:0] alert_prod;

    assign boot_prod  = 65'(now_ms) * 65'(BOOT_RECIP);
    assign call_prod  = 65'(now_ms) * 65'(CALL_RECIP);
    assign alert_prod = 65'(now_ms) * 65'(ALERT_RECIP);

    assign phase.boot  = boot_prod[BOOT_SHIFT];
    assign phase.call  = call_prod[CALL_SHIFT];
    assign phase.alert = alert_prod[ALERT_SHIFT];

endmodule

`default_nettype wire

### sv/slpg_core.sv
// Display state and per-item update logic of the pattern generator.
// Depends on slpg_pkg.
`default_nettype none

module slpg_core
    import slpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  slpg_item_t  item,
    input  slpg_phase_t phase,
    output logic        write,
    output slpg_color_t color
);

    slpg_mode_t  mode_reg;
    slpg_mode_t  mode_next;
    logic [31:0] last_reg;
    logic [31:0] last_next;
    logic [7:0]  level_reg;
    logic [7:0]  level_next;
    logic        falling_reg;
    logic        falling_next;
    logic [31:0] elapsed;
    logic [7:0]  level_step;

    function automatic logic breath_dir(input logic [7:0] lvl, input logic [7:0] top,
                                        input logic [7:0] bottom, input logic cur);
        logic f;
        f = cur;
        if (lvl >= top)
        begin
            f = 1'b1;
        end
        if (lvl <= bottom)
        begin
            f = 1'b0;
        end
        return f;
    endfunction

    assign elapsed    = item.now_ms - last_reg;
    assign level_step = falling_reg ? level_reg - 8'd1 : level_reg + 8'd1;

    always_comb
    begin
        mode_next    = mode_reg;
        last_next    = last_reg;
        level_next   = level_reg;
        falling_next = falling_reg;
        write        = 1'b0;
        color        = COLOR_BLACK;
        if (item.cmd == CMD_SET_MODE)
        begin
            if (slpg_mode_t'(item.mode) != mode_reg)
            begin
                mode_next = slpg_mode_t'(item.mode);
                last_next = '0;
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_BOOT:
                begin
                    if (elapsed > BOOT_PERIOD_MS)
                    begin
                        write     = 1'b1;
                        last_next = item.now_ms;
                        color     = phase.boot ? COLOR_WHITE : COLOR_BLACK;
                    end
                end
                MODE_CALL:
                begin
                    if (elapsed > CALL_PERIOD_MS)
                    begin
                        write     = 1'b1;
                        last_next = item.now_ms;
                        color     = phase.call ? COLOR_WHITE : COLOR_BLACK;
                    end
                end
                MODE_ALERT:
                begin
                    if (elapsed > ALERT_PERIOD_MS)
                    begin
                        write     = 1'b1;
                        last_next = item.now_ms;
                        color     = phase.alert ? COLOR_RED : COLOR_BLACK;
                    end
                end
                MODE_CONNECTING:
                begin
                    if (elapsed > CONN_STEP_MS)
                    begin
                        write        = 1'b1;
                        last_next    = item.now_ms;
                        level_next   = level_step;
                        falling_next = breath_dir(level_step, CONN_TOP, CONN_BOTTOM,
                                                  falling_reg);
                        color        = '{red: 8'd0, green: 8'd0, blue: level_step};
                    end
                end
                MODE_IDLE:
                begin
                    if (elapsed > IDLE_STEP_MS)
                    begin
                        write        = 1'b1;
                        last_next    = item.now_ms;
                        level_next   = level_step;
                        falling_next = breath_dir(level_step, IDLE_TOP, IDLE_BOTTOM,
                                                  falling_reg);
                        color        = '{red: 8'd0, green: level_step, blue: 8'd0};
                    end
                end
                MODE_LINK_OK:
                begin
                    write = 1'b1;
                    color = COLOR_GREEN;
                end
                MODE_STEADY_BLUE:
                begin
                    write = 1'b1;
                    color = COLOR_BLUE;
                end
                MODE_ERROR:
                begin
                    write = 1'b1;
                    color = COLOR_RED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_BOOT;
            last_reg    <= '0;
            level_reg   <= '0;
            falling_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            last_reg    <= last_next;
            level_reg   <= level_next;
            falling_reg <= falling_next;
        end
    end

endmodule

`default_nettype wire

### sv/status_led_pattern_generator_top.sv
// Status LED pattern generator: each beat either selects one of eight display
// modes or asks for an update at a millisecond time, and an update that writes
// the pixel yields one result beat with its color. From input to result an item
// passes one input register, which also holds the blink phases
// found by constant reciprocal multiplies, and one result register after the
// state update. A new item is accepted every cycle while results are taken.
// Depends on slpg_pkg, slpg_if, slpg_phase and slpg_core.
`default_nettype none

module status_led_pattern_generator_top
    import slpg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    slpg_in_if.sink           item,
    slpg_out_if.source        result
);

    logic        in_valid_reg;
    slpg_item_t  in_item_reg;
    slpg_phase_t in_phase_reg;
    logic        out_valid_reg;
    slpg_color_t out_color_reg;

    slpg_phase_t phase;
    logic        advance;
    logic        accept;
    logic        write;
    slpg_color_t color;

    slpg_phase u_phase (
        .now_ms (item.now_ms),
        .phase  (phase)
    );

    slpg_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .phase   (in_phase_reg),
        .write   (write),
        .color   (color)
    );

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign accept     = item.valid && item.ready;

    assign result.valid = out_valid_reg;
    assign result.red   = out_color_reg.red;
    assign result.green = out_color_reg.green;
    assign result.blue  = out_color_reg.blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= write;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg  <= '{cmd: item.cmd, now_ms: item.now_ms, mode: item.mode};
            in_phase_reg <= phase;
        end
        if (advance && write)
        begin
            out_color_reg <= color;
        end
    end

endmodule

`default_nettype wire

### bench/tb_status_led_pattern_generator_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for status_led_pattern_generator_top: directed and random
// beats on the input channel, every color beat checked against an in-bench predictor.
// Depends on slpg_pkg, slpg_if and the RTL of the block.

module tb_status_led_pattern_generator_top;
    import slpg_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;

    slpg_in_if  item_bus();
    slpg_out_if color_bus();

    status_led_pattern_generator_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus.sink),
        .result (color_bus.source)
    );

    slpg_mode_t  shown_mode;
    logic [31:0] last_write_ms;
    logic [7:0]  breath_level;
    logic        breath_falling;

    slpg_color_t pixel_queue[$];

    int  error_count;
    int  beats_sent;
    int  colors_checked;
    int  mode_switches;
    bit  calm;
    bit  hold_request;
    bit  hold_active;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function automatic bit blink_write(input logic [31:0] now, input logic [31:0] period,
                                       input slpg_color_t on_color, output slpg_color_t px);
        logic [31:0] elapsed;
        logic [31:0] quotient;
        elapsed = now - last_write_ms;
        px = COLOR_BLACK;
        if (elapsed <= period)
            return 1'b0;
        quotient = now / period;
        if (quotient[0])
            px = on_color;
        last_write_ms = now;
        return 1'b1;
    endfunction

    function automatic bit breath_step(input logic [31:0] now, input logic [31:0] step_ms,
                                       input logic [7:0] top, input logic [7:0] bottom);
        logic [31:0] elapsed;
        elapsed = now - last_write_ms;
        if (elapsed <= step_ms)
            return 1'b0;
        if (breath_falling)
            breath_level = breath_level - 8'd1;
        else
            breath_level = breath_level + 8'd1;
        if (breath_level >= top)
            breath_falling = 1'b1;
        if (breath_level <= bottom)
            breath_falling = 1'b0;
        last_write_ms = now;
        return 1'b1;
    endfunction

    function automatic bit next_pixel(input slpg_item_t beat, output slpg_color_t px);
        px = COLOR_BLACK;
        if (beat.cmd == CMD_SET_MODE)
        begin
            if (beat.mode != shown_mode)
            begin
                shown_mode = slpg_mode_t'(beat.mode);
                last_write_ms = 32'd0;
            end
            return 1'b0;
        end
        case (shown_mode)
            MODE_BOOT:
                return blink_write(beat.now_ms, BOOT_PERIOD_MS, COLOR_WHITE, px);
            MODE_CALL:
                return blink_write(beat.now_ms, CALL_PERIOD_MS, COLOR_WHITE, px);
            MODE_ALERT:
                return blink_write(beat.now_ms, ALERT_PERIOD_MS, COLOR_RED, px);
            MODE_CONNECTING:
            begin
                if (!breath_step(beat.now_ms, CONN_STEP_MS, CONN_TOP, CONN_BOTTOM))
                    return 1'b0;
                px = '{red: 8'd0, green: 8'd0, blue: breath_level};
                return 1'b1;
            end
            MODE_IDLE:
            begin
                if (!breath_step(beat.now_ms, IDLE_STEP_MS, IDLE_TOP, IDLE_BOTTOM))
                    return 1'b0;
                px = '{red: 8'd0, green: breath_level, blue: 8'd0};
                return 1'b1;
            end
            MODE_LINK_OK:
            begin
                px = COLOR_GREEN;
                return 1'b1;
            end
            MODE_STEADY_BLUE:
            begin
                px = COLOR_BLUE;
                return 1'b1;
            end
            default:
            begin
                px = COLOR_RED;
                return 1'b1;
            end
        endcase
    endfunction

    always @(posedge clk)
    begin : track_pixels
        slpg_item_t  beat;
        slpg_color_t px;
        slpg_color_t want;
        if (rst_n)
        begin
            if (color_bus.valid && color_bus.ready)
            begin
                colors_checked++;
                if (pixel_queue.size() == 0)
                begin
                    report_mismatch($sformatf("color beat (%0d,%0d,%0d) with none pending",
                                              color_bus.red, color_bus.green, color_bus.blue));
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    if (color_bus.red !== want.red)
                        report_mismatch($sformatf("red got %0d expected %0d",
                                                  color_bus.red, want.red));
                    if (color_bus.green !== want.green)
                        report_mismatch($sformatf("green got %0d expected %0d",
                                                  color_bus.green, want.green));
                    if (color_bus.blue !== want.blue)
                        report_mismatch($sformatf("blue got %0d expected %0d",
                                                  color_bus.blue, want.blue));
                end
            end
            if (item_bus.valid && item_bus.ready)
            begin
                beat = '{cmd: item_bus.cmd, now_ms: item_bus.now_ms, mode: item_bus.mode};
                if (beat.cmd == CMD_SET_MODE && beat.mode != shown_mode)
                    mode_switches++;
                if (next_pixel(beat, px))
                    pixel_queue.push_back(px);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input slpg_item_t beat);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid  <= 1'b1;
        item_bus.cmd    <= beat.cmd;
        item_bus.now_ms <= beat.now_ms;
        item_bus.mode   <= beat.mode;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_update(input logic [31:0] now);
        send_item('{cmd: CMD_UPDATE, now_ms: now, mode: 3'($urandom_range(0, 7))});
    endtask

    task automatic send_mode(input slpg_mode_t m);
        send_item('{cmd: CMD_SET_MODE, now_ms: $urandom, mode: m});
    endtask

    initial
    begin : drive_color_ready
        int run;
        int held;
        color_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_active = 1'b1;
                color_bus.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_active = 1'b0;
            end
            else if (calm)
            begin
                color_bus.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                run = pick_gap();
                color_bus.ready <= ($urandom_range(0, 3) != 0);
                repeat (run + 1) @(posedge clk);
            end
        end
    end

    task automatic test_boot_blink();
        send_update(32'd0);
        send_update(32'd200);
        send_update(32'd201);
        send_update(32'd401);
        send_update(32'd402);
    endtask

    task automatic test_time_wrap();
        send_update(32'hFFFF_FFF0);
        send_update(32'h0000_0080);
        send_update(32'h0000_00B9);
    endtask

    task automatic test_mode_switching();
        send_mode(MODE_BOOT);
        send_update(32'd300);
        send_mode(MODE_LINK_OK);
        send_update(32'hFFFF_FFFF);
        send_mode(MODE_STEADY_BLUE);
        send_update(32'd0);
        send_mode(MODE_ERROR);
        send_update(32'd5);
        send_mode(MODE_CALL);
        send_update(32'd301);
        send_mode(MODE_ALERT);
        send_update(32'd999);
        send_mode(MODE_CONNECTING);
        send_update(32'd11);
        send_update(32'd21);
        send_mode(MODE_IDLE);
        send_update(32'd16);
    endtask

    task automatic test_output_backpressure();
        send_mode(MODE_STEADY_BLUE);
        item_bus.valid <= 1'b0;
        calm = 1'b1;
        hold_request = 1'b1;
        while (!hold_active)
            @(posedge clk);
        repeat (24) send_update($urandom);
        calm = 1'b0;
    endtask

    function automatic int step_time(input slpg_mode_t m);
        case (m)
            MODE_BOOT:       return BOOT_PERIOD_MS;
            MODE_CALL:       return CALL_PERIOD_MS;
            MODE_ALERT:      return ALERT_PERIOD_MS;
            MODE_CONNECTING: return CONN_STEP_MS;
            MODE_IDLE:       return IDLE_STEP_MS;
            default:         return 50;
        endcase
    endfunction

    task automatic test_random_traffic(input int target);
        int          first;
        int          n;
        int          r;
        int          thr;
        logic [31:0] t;
        slpg_mode_t  m;
        slpg_item_t  noise;
        first = beats_sent;
        m = slpg_mode_t'($urandom_range(0, 7));
        send_mode(m);
        while (beats_sent - first < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                m = $urandom_range(0, 1) ? MODE_CONNECTING : MODE_IDLE;
            else if (r < 90)
                m = slpg_mode_t'($urandom_range(0, 7));
            send_mode(m);
            calm = ($urandom_range(0, 5) == 0);
            thr = step_time(m);
            n = (m == MODE_CONNECTING || m == MODE_IDLE) ? $urandom_range(20, 150)
                                                          : $urandom_range(3, 40);
            t = $urandom;
            repeat (n)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    noise = '{cmd: CMD_SET_MODE, now_ms: $urandom,
                              mode: 3'($urandom_range(0, 7))};
                    m = slpg_mode_t'(noise.mode);
                    thr = step_time(m);
                    send_item(noise);
                end
                else if (r < 8)
                begin
                    send_update($urandom);
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 55)
                        t = t + thr + $urandom_range(0, 2);
                    else if (r < 75)
                        t = t + $urandom_range(0, thr);
                    else if (r < 92)
                        t = t + thr * $urandom_range(2, 6) + $urandom_range(0, thr);
                    else
                        t = t + $urandom;
                    send_update(t);
                end
            end
            calm = 1'b0;
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        item_bus.valid  <= 1'b0;
        item_bus.cmd    <= CMD_UPDATE;
        item_bus.now_ms <= 32'd0;
        item_bus.mode   <= MODE_BOOT;
        shown_mode = MODE_BOOT;
        last_write_ms = 32'd0;
        breath_level = 8'd0;
        breath_falling = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_boot_blink();
        test_time_wrap();
        test_mode_switching();
        test_output_backpressure();
        test_random_traffic(1100);

        item_bus.valid <= 1'b0;
        while (pixel_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d input beats including %0d mode switches; checked %0d color beats.",
                 beats_sent, mode_switches, colors_checked);
        $display("Traffic covered all eight modes, time wraparound and a long output stall.");
        if (error_count == 0)
            $display("status_led_pattern_generator_top regression: pass");
        else
            $display("status_led_pattern_generator_top regression: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d color beats still pending.", pixel_queue.size());
        $display("status_led_pattern_generator_top regression: fail");
        $finish;
    end

endmodule
